// ===== rtl/fp8c_pkg.sv =====
`timescale 1ns / 1ps
package fp8c_pkg;

  localparam logic       REQ_ENCODE = 1'b0;
  localparam logic       REQ_DECODE = 1'b1;
  localparam logic [7:0] FP8_NAN    = 8'h7F;
  localparam logic [6:0] FP8_MAX    = 7'h7E;
  localparam logic [31:0] F32_448   = 32'h43E00000;

  typedef struct packed {
    logic        req_type;
    logic [31:0] float_bits;
    logic [7:0]  fp8_code;
  } fp8c_req_t;

  typedef struct packed {
    logic [7:0]  fp8_result;
    logic [31:0] float_result;
    logic        was_clamped;
  } fp8c_res_t;

endpackage

// ===== rtl/fp8_e4m3_converter_top.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (low bit up)                  | tuser
// in_     | in  | float_bits[31:0], fp8_code[39:32]           | req_type
// out_    | out | fp8_result[7:0], float_result[39:8]        | was_clamped
//
// One transaction per cycle sustained while the output is not stalled; each passes
// the input register, then the result register, with conversion logic between the two.
// Synchronous active-low reset clears both valid flags.
// A stalled output holds its result; the input register advances whenever
// the result register is free or being drained.
module fp8_e4m3_converter_top import fp8c_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // float_bits, fp8_code
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // fp8_result, float_result
  output logic        out_tuser   // was_clamped
);

  fp8c_req_t   req_r;
  fp8c_res_t   res_r, res_nxt;
  logic        req_vld_r, res_vld_r;
  logic        adv;
  logic [7:0]  enc8;
  logic        enc_clamp;
  logic [31:0] dec32;

  assign adv       = !res_vld_r || out_tready;
  assign in_tready = !req_vld_r || adv;

  fp8c_encode u_enc (.float_bits(req_r.float_bits), .fp8_result(enc8),
                     .was_clamped(enc_clamp));
  fp8c_decode u_dec (.fp8_code(req_r.fp8_code), .float_result(dec32));

  // Pick the direction's outputs, zero the other side
  always_comb begin
    if (req_r.req_type == REQ_DECODE) begin
      res_nxt = '{fp8_result: 8'd0, float_result: dec32, was_clamped: 1'b0};
    end else begin
      res_nxt = '{fp8_result: enc8, float_result: 32'd0, was_clamped: enc_clamp};
    end
  end

  // Advance the two-stage pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_tready) req_vld_r <= in_tvalid;
      if (adv) res_vld_r <= req_vld_r;
    end
    if (in_tready && in_tvalid) begin
      req_r <= '{req_type: in_tuser, float_bits: in_tdata[31:0],
                 fp8_code: in_tdata[39:32]};
    end
    if (adv && req_vld_r) res_r <= res_nxt;
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {res_r.float_result, res_r.fp8_result};
  assign out_tuser  = res_r.was_clamped;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_dec_noclamp: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && adv && req_r.req_type == REQ_DECODE |=> !out_tuser && out_tdata[7:0] == 8'd0)
    else $error("decode result carries encode fields");
  a_enc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && adv && req_r.req_type == REQ_ENCODE |=> out_tdata[39:8] == 32'd0)
    else $error("encode result carries decode fields");

endmodule

// ===== rtl/fp8c_encode.sv =====
`timescale 1ns / 1ps
module fp8c_encode import fp8c_pkg::*; (
  input  logic [31:0] float_bits,
  output logic [7:0]  fp8_result,
  output logic        was_clamped
);

  logic [7:0]  ex;
  logic [23:0] sig;
  logic [4:0]  shift;
  logic [6:0]  mag;
  logic [23:0] shd;
  logic [4:0]  q;
  logic        sgn;

  assign ex  = float_bits[30:23];
  assign sig = {1'b1, float_bits[22:0]};
  assign sgn = float_bits[31];

  // Normal range (ex >= 121) uses a fixed shift; subnormals shift further
  // Keep the rounding carry in q so it can ripple into the exponent
  always_comb begin
    shift = 5'd20;
    if (ex < 8'd121) begin
      shift = (8'd141 - ex > 8'd25) ? 5'd25 : 5'(8'd141 - ex);
    end
    shd = sig >> (shift - 5'd1);
    q   = 5'((shd >> 1) + (shd & 24'd1));
    mag = 7'd0;
    if (ex != 8'd0 && shift <= 5'd24) begin
      if (ex >= 8'd121) begin
        mag = 7'({ex - 8'd121, 3'b000} + {6'd0, q});
      end else begin
        mag = {2'd0, q};
      end
    end
  end

  // Select special, saturated or rounded result
  always_comb begin
    was_clamped = 1'b0;
    fp8_result  = {sgn, mag};
    if (ex == 8'hFF) begin
      fp8_result  = FP8_NAN;
      was_clamped = 1'b1;
    end else if (float_bits[30:0] > F32_448[30:0]) begin
      fp8_result  = {sgn, FP8_MAX};
      was_clamped = 1'b1;
    end
  end

endmodule

// ===== rtl/fp8c_decode.sv =====
`timescale 1ns / 1ps
module fp8c_decode import fp8c_pkg::*; (
  input  logic [7:0]  fp8_code,
  output logic [31:0] float_result
);

  logic [3:0] ex;
  logic [2:0] mn;
  logic [1:0] p;
  logic [2:0] frac;

  assign ex = fp8_code[6:3];
  assign mn = fp8_code[2:0];

  // Map the NaN code to +/-448, rebias normal codes and normalise a subnormal code by its leading one
  always_comb begin
    p = mn[2] ? 2'd2 : (mn[1] ? 2'd1 : 2'd0);
    frac = mn - (3'd1 << p);
    float_result = {fp8_code[7], 31'd0};
    if (fp8_code[6:0] == FP8_NAN[6:0]) begin
      float_result = {fp8_code[7], F32_448[30:0]};
    end else if (ex != 4'd0) begin
      float_result = {fp8_code[7], 8'(ex + 8'd120), mn, 20'd0};
    end else if (mn != 3'd0) begin
      float_result = {fp8_code[7], 8'(p + 8'd118), 23'({20'd0, frac} << (23 - p))};
    end
  end

endmodule

// ===== verif/fp8_e4m3_converter_top_test.sv =====
`timescale 1ns / 1ps
module fp8_e4m3_converter_top_test;
  import fp8c_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // float_bits[31:0], fp8_code[39:32]
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // fp8_result[7:0], float_result[39:8]
  logic        out_tuser;  // was_clamped

  fp8c_req_t pending_reqs[$];
  fp8c_res_t expected_results[$];
  int        errors = 0;
  bit        stim_done = 0;
  int        in_gap = 0;
  int        out_gap = 0;

  fp8_e4m3_converter_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Encoded magnitude of a finite binary32 value no larger than 448
  function automatic logic [7:0] encode_magnitude(input logic [31:0] bits);
    logic [7:0]  bexp;
    logic [23:0] sig;
    int          e;
    int          shift;
    logic [31:0] q;
    bexp = bits[30:23];
    sig = {1'b1, bits[22:0]};
    e = int'(bexp) - 127;
    if (bexp == 8'd0) return 8'd0;
    shift = (e >= -6) ? 20 : 20 + (-6 - e);
    if (shift > 24) return 8'd0;
    q = (32'(sig) >> shift) + ((32'(sig) >> (shift - 1)) & 32'd1);
    if (e >= -6) return 8'(((e + 6) << 3) + q);
    return 8'(q);
  endfunction

  // Exact binary32 value of an E4M3 code; the NaN code maps to +/-448
  function automatic logic [31:0] decode_code(input logic [7:0] code);
    logic [31:0] sgn;
    logic [3:0]  cexp;
    logic [2:0]  mn;
    int          p;
    sgn = code[7] ? 32'h8000_0000 : 32'd0;
    cexp = code[6:3];
    mn = code[2:0];
    if (code[6:0] == FP8_NAN[6:0]) return sgn | F32_448;
    if (cexp != 4'd0) return sgn | ((32'(cexp) + 32'd120) << 23) | (32'(mn) << 20);
    if (mn == 3'd0) return sgn;
    p = mn[2] ? 2 : (mn[1] ? 1 : 0);
    return sgn | ((32'(p) + 32'd118) << 23) | ((32'(mn) - (32'd1 << p)) << (23 - p));
  endfunction

  function automatic fp8c_res_t convert(input fp8c_req_t r);
    fp8c_res_t res;
    logic [31:0] mag;
    res = '0;
    if (r.req_type == REQ_ENCODE) begin
      mag = r.float_bits & 32'h7FFF_FFFF;
      if (r.float_bits[30:23] == 8'hFF) begin
        res.fp8_result = FP8_NAN;
        res.was_clamped = 1'b1;
      end else if (mag > F32_448) begin
        res.fp8_result = {r.float_bits[31], FP8_MAX};
        res.was_clamped = 1'b1;
      end else begin
        res.fp8_result = {r.float_bits[31], 7'd0} | encode_magnitude(mag);
      end
    end else begin
      res.float_result = decode_code(r.fp8_code);
    end
    return res;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic push_req(input logic rt, input logic [31:0] fb, input logic [7:0] code);
    fp8c_req_t r;
    r.req_type = rt;
    r.float_bits = fb;
    r.fp8_code = code;
    pending_reqs.push_back(r);
  endtask

  // Build directed and random stimulus, then wait for completion
  initial begin
    logic [31:0] fb;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    push_req(REQ_ENCODE, 32'h0000_0000, 8'h00);
    push_req(REQ_ENCODE, 32'h8000_0000, 8'hFF);
    push_req(REQ_ENCODE, 32'h7F80_0000, 8'h00);
    push_req(REQ_ENCODE, 32'hFFC0_0001, 8'h00);
    push_req(REQ_ENCODE, 32'h43E0_0000, 8'h00);
    push_req(REQ_ENCODE, 32'hC3E0_0001, 8'h00);
    push_req(REQ_ENCODE, 32'h7F7F_FFFF, 8'h00);
    push_req(REQ_ENCODE, 32'h3A80_0000, 8'h00);
    push_req(REQ_ENCODE, 32'h3A7F_FFFF, 8'h00);
    push_req(REQ_ENCODE, 32'h807F_FFFF, 8'h00);
    push_req(REQ_ENCODE, 32'h3F7F_FFFF, 8'h00);
    push_req(REQ_ENCODE, 32'h3F88_0000, 8'h00);
    push_req(REQ_ENCODE, 32'h3C00_0000, 8'h00);
    push_req(REQ_ENCODE, 32'hFFFF_FFFF, 8'hFF);
    push_req(REQ_DECODE, 32'hFFFF_FFFF, 8'h00);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h80);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h7F);
    push_req(REQ_DECODE, 32'h0000_0000, 8'hFF);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h7E);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h78);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h01);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h86);
    push_req(REQ_DECODE, 32'h0000_0000, 8'h08);
    for (int i = 0; i < 700; i++) begin
      fb = $urandom();
      // Steer most encodes into the exponent window that E4M3 covers
      if ($urandom_range(0, 3) != 0) fb[30:23] = 8'($urandom_range(110, 136));
      push_req(1'($urandom_range(0, 1)), fb, 8'($urandom_range(0, 255)));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);
    stim_done = 1;
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Driver: present queued items with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(convert({in_tuser, in_tdata[31:0], in_tdata[39:32]}));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          fp8c_req_t r;
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {r.fp8_code, r.float_bits};
          in_tuser <= r.req_type;
          in_gap <= random_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result tdata=%h tuser=%b", $realtime, out_tdata,
                   out_tuser);
        end else begin
          fp8c_res_t ex;
          ex = expected_results.pop_front();
          if (out_tdata[7:0] !== ex.fp8_result) begin
            errors++;
            $display("%0t: fp8_result expected %h actual %h", $realtime, ex.fp8_result,
                     out_tdata[7:0]);
          end
          if (out_tdata[39:8] !== ex.float_result) begin
            errors++;
            $display("%0t: float_result expected %h actual %h", $realtime,
                     ex.float_result, out_tdata[39:8]);
          end
          if (out_tuser !== ex.was_clamped) begin
            errors++;
            $display("%0t: was_clamped expected %b actual %b", $realtime, ex.was_clamped,
                     out_tuser);
          end
        end
      end
      // Stall the result side at random
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap <= random_gap();
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    if (!stim_done) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
